>>> rtl/khv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Key hit velocity detector: shared package
// Sizes, field layout, register indices and the structs passed between the
// controller and the bit-serial velocity scaler.
// ---------------------------------------------------------------------------
package khv_pkg;

  // Number of keys tracked and the sample bits actually used.
  localparam int NOTE_COUNT  = 88;
  localparam int SAMPLE_BITS = 12;

  // Field widths.
  localparam int NOTE_W   = 7;
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 12;
  localparam int VEL_W    = 7;
  localparam int BOUNCE_W = 16;

  localparam logic [VEL_W-1:0] VEL_MAX = {VEL_W{1'b1}};

  // Per-key storage: {release time, previous sample}.
  localparam int ADDR_W  = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int ENTRY_W = TIME_W + SAMPLE_W;

  localparam logic [NOTE_W:0] NOTE_LIMIT = (NOTE_W + 1)'(NOTE_COUNT);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // Velocity numerator: (sample - active) * VEL_MAX.
  localparam int NUM_W = SAMPLE_W + VEL_W;
  localparam int CNT_W = $clog2(VEL_W + 1);

  // Stream word layouts.
  localparam int IN_TDATA_W  = ((NOTE_W + TIME_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NOTE_W + VEL_W + 7) / 8) * 8;
  localparam int IN_NOTE_LSB   = 0;
  localparam int IN_TIME_LSB   = NOTE_W;
  localparam int IN_SAMPLE_LSB = NOTE_W + TIME_W;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BOUNCE_DELAY = 2'd0,
    CFG_ACTIVE_THR   = 2'd1,
    CFG_FULL_THR     = 2'd2
  } cfg_idx_t;

  localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = BOUNCE_W'(50);
  localparam logic [SAMPLE_W-1:0] ACTIVE_RESET = SAMPLE_W'(400);
  localparam logic [SAMPLE_W-1:0] FULL_RESET   = SAMPLE_W'(3000);

  // Controller to scaler.
  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W-1:0] span;
  } div_req_t;

  // Scaler to controller.
  typedef struct packed {
    logic             done;
    logic [VEL_W-1:0] vel;
  } div_stat_t;

endpackage
`default_nettype wire

>>> rtl/khv_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module khv_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/khv_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bit-serial velocity scaler
// Restoring division, one quotient bit per cycle, saturating at full scale.
// ---------------------------------------------------------------------------
module khv_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire khv_pkg::div_req_t   req,
  output khv_pkg::div_stat_t       stat
);
  import khv_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VEL_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsr_r, dsr_nxt;
  logic [VEL_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  assign ge = (rem_r >= dsr_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      dsr_nxt  = {req.span, {VEL_W{1'b0}}};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        // A quotient above full scale saturates straight away.
        if (ge) begin
          q_nxt    = VEL_MAX;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          dsr_nxt = dsr_r >> 1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end else begin
        if (ge) begin
          rem_nxt = rem_r - dsr_r;
        end
        q_nxt   = {q_r[VEL_W-2:0], ge};
        dsr_nxt = dsr_r >> 1;
        if (cnt_r == CNT_LAST) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign stat.done = done_r;
  assign stat.vel  = q_r;

endmodule
`default_nettype wire

>>> rtl/key_hit_velocity_detector.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Key hit velocity detector
// Watches scanned key-sensor samples, detects strikes and releases per key
// and reports each strike with a velocity scaled between two thresholds.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Word contents (lowest bit first)
//  in_      slave      note_index[6:0], time_ms[38:7], sample[50:39], zero pad
//  out_     master     hit_note[6:0], velocity[13:7], zero pad
//  cfg_     write      index 0 bounce delay in ms, 1 press threshold, 2 full threshold
//
// Flow: one word at a time. A word with no strike is accepted with the per-key RAM
// read, then evaluated and written back; a strike adds a hand-off state and, unless
// the full threshold sits at or below the press threshold, a pass through the
// bit-serial scaler, which ends early when it saturates or else forms all seven bits.
// Reset: rst_n is synchronous and active low; it clears the per-key valid bits.
// Stalls: a strike waits only while the output register holds an untaken word.
// ---------------------------------------------------------------------------
module key_hit_velocity_detector (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // note_index, time_ms, sample
  input  wire logic [khv_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // hit_note, velocity
  output logic      [khv_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_we,
  input  wire logic [khv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [khv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import khv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [BOUNCE_W-1:0] bounce_r;
  logic [SAMPLE_W-1:0] active_r;
  logic [SAMPLE_W-1:0] full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounce_r <= BOUNCE_RESET;
      active_r <= ACTIVE_RESET;
      full_r   <= FULL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BOUNCE_DELAY: bounce_r <= cfg_wdata[BOUNCE_W-1:0];
        CFG_ACTIVE_THR:   active_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_FULL_THR:     full_r   <= cfg_wdata[SAMPLE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Input word fields.
  logic [NOTE_W-1:0]   in_note;
  logic [TIME_W-1:0]   in_time;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_acc;
  logic                in_range;

  assign in_note   = in_tdata[IN_NOTE_LSB +: NOTE_W];
  assign in_time   = in_tdata[IN_TIME_LSB +: TIME_W];
  assign in_sample = in_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = ({1'b0, in_note} < NOTE_LIMIT);

  // Captured word; payload only, so no reset.
  logic [NOTE_W-1:0]   note_r;
  logic [TIME_W-1:0]   time_r;
  logic [SAMPLE_W-1:0] cur_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      note_r <= in_note;
      time_r <= in_time;
      cur_r  <= in_sample & SAMPLE_MASK;
    end
  end

  // Per-key store: {release time, previous sample}. An entry that has never
  // been written reads as zero through its valid bit.
  logic [NOTE_COUNT-1:0] valid_r;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [ADDR_W-1:0]     wr_addr;

  assign wr_addr = note_r[ADDR_W-1:0];

  khv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_note[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Evaluation of the stored entry against the new sample.
  logic [SAMPLE_W-1:0] last;
  logic [TIME_W-1:0]   rel;
  logic [TIME_W-1:0]   elapsed;
  logic                changed;
  logic                open;
  logic                hit;
  logic                release_ev;
  logic                degenerate;
  logic [SAMPLE_W-1:0] diff;

  assign last       = valid_r[wr_addr] ? ram_rdata[SAMPLE_W-1:0] : '0;
  assign rel        = valid_r[wr_addr] ? ram_rdata[ENTRY_W-1:SAMPLE_W] : '0;
  assign elapsed    = time_r - rel;
  assign changed    = (cur_r != last);
  // Lockout: no strike or release counts until the bounce delay has passed since release.
  assign open       = (elapsed >= TIME_W'(bounce_r));
  assign hit        = changed && open && (cur_r > active_r) && (last < active_r);
  assign release_ev = changed && open && (cur_r <= active_r) && (last > active_r);
  assign degenerate = (full_r <= active_r);
  assign diff       = cur_r - active_r;

  // The whole entry is rewritten every time, so one valid bit covers both.
  assign ram_we    = (state_r == ST_EVAL);
  assign ram_wdata = {release_ev ? time_r : rel, cur_r};

  // Velocity scaler: numerator is diff * VEL_MAX, done as shift and subtract.
  div_req_t  div_req;
  div_stat_t div_stat;

  assign div_req.start = (state_r == ST_EVAL) && hit && !degenerate;
  assign div_req.num   = {diff, {VEL_W{1'b0}}} - NUM_W'(diff);
  assign div_req.span  = full_r - active_r;

  khv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  // Result hand-off.
  logic [VEL_W-1:0]  vel_r, vel_nxt;
  logic [NOTE_W-1:0] out_note_r;
  logic [VEL_W-1:0]  out_vel_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    vel_nxt   = vel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_range) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (hit && degenerate) begin
          vel_nxt   = VEL_MAX;
          state_nxt = ST_FIN;
        end else if (hit) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          vel_nxt   = div_stat.vel;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    vel_r <= vel_nxt;
    if (out_load) begin
      out_note_r <= note_r;
      out_vel_r  <= vel_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_vel_r, out_note_r});

`ifndef SYNTHESIS
  // An in-range word is evaluated in the very next cycle.
  a_eval_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_range) |=> (state_r == ST_EVAL))
    else $error("accepted word was not evaluated");

  // The scaler only finishes while the controller waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("scaler finished outside the division state");

  // A pending strike never overwrites a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_tready) |=> (state_r == ST_FIN))
    else $error("strike left the hold state while output was full");

  // A result only appears after a strike was held for hand-off.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("output word appeared without a strike");
`endif

endmodule
`default_nettype wire

>>> test/tb_key_hit_velocity_detector.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key hit velocity detector testbench
// Sends scanned key samples through the input stream, keeps its own per-key
// picture of levels and release times, and checks every strike word against
// the strike it works out itself. A directed part covers lockout, threshold
// equality, saturation, out-of-range keys and time wrap; random key strokes
// then run under several register settings and idling mixes.
// ---------------------------------------------------------------------------
module tb_key_hit_velocity_detector;
  import khv_pkg::*;

  // Cycles in which no word moves on any port before the run is declared hung. The
  // limit is generous next to the time the block needs per word, even with random
  // stalls on either side.
  localparam int STALL_LIMIT   = 2000;
  // Cycles allowed for a word that gives no strike to finish internally.
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } strike_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  // note_index, time_ms, sample, zero pad
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  // hit_note, velocity, zero pad
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;

  // Idling mix, in percent of cycles, for each side of the block.
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 50;

  int mismatches   = 0;
  int quiet_cycles = 0;

  // Our own copy of the registers and of the per-key state.
  logic [BOUNCE_W-1:0] bounce_ms  = BOUNCE_RESET;
  logic [SAMPLE_W-1:0] active_lvl = ACTIVE_RESET;
  logic [SAMPLE_W-1:0] full_lvl   = FULL_RESET;
  logic [SAMPLE_W-1:0] key_level      [NOTE_COUNT];
  logic [TIME_W-1:0]   key_release_ms [NOTE_COUNT];

  // Strikes worked out but not yet seen on the output, oldest first.
  strike_t strikes_due[$];

  // Running millisecond clock for the random key strokes.
  logic [TIME_W-1:0] now_ms = 32'd100000;

  key_hit_velocity_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Velocity of a strike: the rise above the active level scaled so that the
  // full level maps to the top value, saturating above it. When the full
  // level does not sit above the active level every strike is at full force.
  function automatic logic [VEL_W-1:0] strike_velocity(logic [SAMPLE_W-1:0] level);
    int unsigned rise;
    int unsigned span;
    int unsigned scaled;
    if (full_lvl <= active_lvl) return VEL_MAX;
    rise   = level - active_lvl;
    span   = full_lvl - active_lvl;
    scaled = (rise * VEL_MAX) / span;
    return (scaled > VEL_MAX) ? VEL_MAX : VEL_W'(scaled);
  endfunction

  // Applies one accepted sample to our per-key state and queues the strike
  // it gives, if any.
  task automatic track_sample(logic [NOTE_W-1:0] key_idx, logic [TIME_W-1:0] now,
                              logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] held;
    logic [TIME_W-1:0]   elapsed;
    strike_t             hit;
    level = raw & SAMPLE_MASK;
    // Keys beyond the scanned range are dropped without touching anything.
    if (key_idx >= NOTE_COUNT) return;
    held = key_level[key_idx];
    if (level != held) begin
      // Time differences wrap, so the subtraction is done at 32 bits.
      elapsed = now - key_release_ms[key_idx];
      if (elapsed >= bounce_ms) begin
        if (level > active_lvl) begin
          // A strike needs the key to come from strictly below the level.
          if (held < active_lvl) begin
            hit.note = key_idx;
            hit.vel  = strike_velocity(level);
            strikes_due.push_back(hit);
          end
        end else if (held > active_lvl) begin
          key_release_ms[key_idx] = now;
        end
      end
    end
    // The stored level follows the sample even inside the lockout.
    key_level[key_idx] = level;
  endtask

  // ------------------------------------------------------------------------
  // Stimulus plumbing
  // ------------------------------------------------------------------------

  // Offers one word on the input stream, with random idle cycles in front,
  // and records it once the block has taken it. tvalid stays high after the
  // handshake so that back-to-back words need no extra assignment.
  task automatic send_sample(logic [NOTE_W-1:0] key_idx, logic [TIME_W-1:0] now,
                             logic [SAMPLE_W-1:0] level);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= IN_TDATA_W'({level, now, key_idx});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_sample(key_idx, now, level);
  endtask

  // Waits for every strike to be delivered, then lets any word that gives no
  // strike finish inside the block.
  task automatic wait_until_drained();
    @(posedge clk);
    while (strikes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle, once the block is idle.
  task automatic apply_config(logic [BOUNCE_W-1:0] bounce, logic [SAMPLE_W-1:0] active,
                              logic [SAMPLE_W-1:0] full);
    in_tvalid <= 1'b0;
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BOUNCE_DELAY;
    cfg_wdata <= CFG_DATA_W'(bounce);
    @(posedge clk);
    cfg_addr  <= CFG_ACTIVE_THR;
    cfg_wdata <= CFG_DATA_W'(active);
    @(posedge clk);
    cfg_addr  <= CFG_FULL_THR;
    cfg_wdata <= CFG_DATA_W'(full);
    @(posedge clk);
    cfg_we    <= 1'b0;
    bounce_ms  = bounce;
    active_lvl = active;
    full_lvl   = full;
  endtask

  // Moves the stroke clock on. Steps are chosen so that a fair share land
  // just inside or just outside the lockout window, with the odd jump to an
  // arbitrary time to exercise the wrap of the time difference.
  task automatic advance_clock();
    case ($urandom_range(9, 0))
      0, 1:    now_ms = now_ms + $urandom_range(3, 0);
      2, 3:    now_ms = now_ms + bounce_ms + $urandom_range(2, 0) - 1;
      9:       now_ms = $urandom;
      default: now_ms = now_ms + bounce_ms + $urandom_range(2000, 0);
    endcase
  endtask

  // A resting level: below the active level, now and then exactly on it.
  function automatic logic [SAMPLE_W-1:0] rest_level();
    if (active_lvl == 0 || $urandom_range(7, 0) == 0) return active_lvl;
    return SAMPLE_W'($urandom_range(active_lvl - 1, 0));
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Release times start at zero, so early samples sit in the lockout. Also
  // covers a release, a press inside the lockout, a full-scale strike right
  // on the lockout boundary and a repeated sample that must do nothing.
  task automatic test_lockout_from_reset();
    send_sample(7'd5, 32'd10,  12'd1000);
    send_sample(7'd5, 32'd60,  12'd0);
    send_sample(7'd5, 32'd100, 12'd3000);
    send_sample(7'd5, 32'd120, 12'd0);
    send_sample(7'd5, 32'd170, 12'd3000);
    send_sample(7'd5, 32'd170, 12'd3000);
  endtask

  // Saturation above the full level, the smallest strike just above the
  // active level on the last key, and keys beyond the scanned range.
  task automatic test_velocity_extremes();
    send_sample(7'd0,                     32'd200,       12'hFFF);
    send_sample(NOTE_W'(NOTE_COUNT - 1),  32'd200,       12'd401);
    send_sample(NOTE_W'(NOTE_COUNT),      32'd200,       12'hFFF);
    send_sample(7'h7F,                    32'hFFFF_FFFF, 12'hFFF);
  endtask

  // A sample equal to the active level neither strikes nor counts as coming
  // from below it, but does count as a release.
  task automatic test_threshold_equality();
    send_sample(7'd1, 32'd200, 12'd400);
    send_sample(7'd1, 32'd300, 12'd2000);
    send_sample(7'd1, 32'd400, 12'd400);
    send_sample(7'd1, 32'd500, 12'd500);
  endtask

  // Full level below the active level gives full force on every strike; the
  // longest lockout is checked against its edge and across the time wrap.
  task automatic test_degenerate_scale_and_wrap();
    apply_config(16'hFFFF, 12'd100, 12'd50);
    send_sample(7'd3, 32'd70000,       12'd2000);
    send_sample(7'd3, 32'd70001,       12'd50);
    send_sample(7'd3, 32'd135535,      12'd2000);
    send_sample(7'd4, 32'hFFFF_FFF0,   12'hFFF);
    send_sample(7'd4, 32'hFFFF_FFFF,   12'd0);
    send_sample(7'd4, 32'h0000_0010,   12'hFFF);
  endtask

  // Random key strokes under one register setting: mostly well-formed
  // press/release sequences on a handful of keys, with some noise words that
  // may land on any key, out of range included.
  task automatic test_random_keys(int unsigned send_pct, int unsigned recv_pct,
                                  int unsigned items, logic [BOUNCE_W-1:0] bounce,
                                  logic [SAMPLE_W-1:0] active, logic [SAMPLE_W-1:0] full);
    int unsigned       sent;
    int unsigned       presses;
    logic [NOTE_W-1:0] key_idx;
    logic [SAMPLE_W-1:0] level;
    apply_config(bounce, active, full);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99, 0) < 15) begin
        key_idx = NOTE_W'($urandom_range(127, 0));
        advance_clock();
        send_sample(key_idx, ($urandom_range(3, 0) == 0) ? $urandom : now_ms,
                    SAMPLE_W'($urandom_range(4095, 0)));
        if (key_idx < NOTE_COUNT) sent++;
      end else begin
        // Few keys most of the time, so that strokes overlap on the same key.
        case ($urandom_range(3, 0))
          0:       key_idx = NOTE_W'(NOTE_COUNT - 1);
          1:       key_idx = NOTE_W'($urandom_range(NOTE_COUNT - 1, 0));
          default: key_idx = NOTE_W'($urandom_range(3, 0));
        endcase
        advance_clock();
        send_sample(key_idx, now_ms, rest_level());
        presses = $urandom_range(3, 1);
        repeat (presses) begin
          if (active_lvl == SAMPLE_MASK) level = SAMPLE_MASK;
          else level = SAMPLE_W'($urandom_range(4095, active_lvl + 1));
          advance_clock();
          send_sample(key_idx, now_ms, level);
        end
        advance_clock();
        send_sample(key_idx, now_ms, rest_level());
        sent += presses + 2;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Receiver, result checking and watchdog
  // ------------------------------------------------------------------------

  always @(posedge clk) out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);

  // Every strike word taken from the block is compared with the oldest
  // strike still owed.
  always @(posedge clk) begin : check_strikes
    strike_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (strikes_due.size() == 0) begin
        $error("strike word with none expected: hit_note %0d velocity %0d",
               out_tdata[NOTE_W-1:0], out_tdata[NOTE_W +: VEL_W]);
        mismatches++;
      end else begin
        due = strikes_due.pop_front();
        if (out_tdata[NOTE_W-1:0] !== due.note) begin
          $error("hit_note: expected %0d, actual %0d", due.note, out_tdata[NOTE_W-1:0]);
          mismatches++;
        end
        if (out_tdata[NOTE_W +: VEL_W] !== due.vel) begin
          $error("velocity: expected %0d, actual %0d", due.vel, out_tdata[NOTE_W +: VEL_W]);
          mismatches++;
        end
      end
    end
  end

  // Counts cycles in which no word moves on any port; a hung block or a
  // missing strike ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_key_hit_velocity_detector failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NOTE_COUNT; i++) begin
      key_level[i]      = '0;
      key_release_ms[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset register values first.
    test_lockout_from_reset();
    test_velocity_extremes();
    test_threshold_equality();
    test_degenerate_scale_and_wrap();

    // Sender idles lightly, receiver stalls half the time.
    test_random_keys(12, 50, 200, 16'd0,     12'd2048, 12'd4095);
    test_random_keys(12, 50,  80, 16'hFFFF,  12'd1,    12'd4094);
    // The other way round, including settings where no strike can happen.
    test_random_keys(50, 12,  40, 16'd300,   12'd0,    12'd0);
    test_random_keys(50, 12,  40, 16'd20,    12'hFFF,  12'hFFF);
    test_random_keys(50, 12, 200, 16'd7,     12'd1000, 12'd1000);
    // Neither side idles.
    test_random_keys(0,  0,  120, 16'd100,   12'd3000, 12'd200);
    test_random_keys(0,  0,  170, BOUNCE_W'($urandom_range(500, 0)),
                     SAMPLE_W'($urandom_range(4000, 1)), SAMPLE_W'($urandom_range(4095, 0)));

    in_tvalid <= 1'b0;
    wait_until_drained();
    if (mismatches == 0) begin
      $display("tb_key_hit_velocity_detector passed");
    end else begin
      $display("tb_key_hit_velocity_detector failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/khv_pkg.sv
rtl/khv_ram.sv
rtl/khv_div.sv
rtl/key_hit_velocity_detector.sv
test/tb_key_hit_velocity_detector.sv
